// ===== src/tri_zb_pkg.sv =====
// Shared types, constants and edge stepper functions for the triangle z-buffer rasterizer.
package tri_zb_pkg;

	// screen and store geometry
	localparam int SCREEN_W = 64;
	localparam int SCREEN_H = 64;
	localparam int NPIX     = SCREEN_W * SCREEN_H;
	localparam int ADDR_W   = $clog2(NPIX);
	localparam int XY_W     = 6;
	localparam int DEPTH_W  = 16;
	localparam int COLOR_W  = 32;
	localparam logic [DEPTH_W-1:0] DMAX = '1;

	// inverse depth is 2^(DEPTH_W+16) / z, 1/z in Q1.32, up to 33 bits
	localparam int INV_W = DEPTH_W + 17;
	// divider widths
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = INV_W;
	localparam logic [DIV_NUM_W-1:0] INV_NUM = DIV_NUM_W'(1) << (DEPTH_W + 16);

	// command codes
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_DRAW  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// interpolation targets
	localparam logic [1:0] LS_I1  = 2'd0;
	localparam logic [1:0] LS_I2  = 2'd1;
	localparam logic [1:0] LS_PIX = 2'd2;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [XY_W-1:0]    ax;
		logic [XY_W-1:0]    ay;
		logic [15:0]        az;
		logic [XY_W-1:0]    bx;
		logic [XY_W-1:0]    by_row;
		logic [15:0]        bz;
		logic [XY_W-1:0]    cx;
		logic [XY_W-1:0]    cy;
		logic [15:0]        cz;
		logic [COLOR_W-1:0] fill_color;
	} in_item_t;

	typedef struct packed {
		logic [COLOR_W-1:0] pixel_color;
		logic [15:0]        pixel_depth;
		logic               status;
	} out_item_t;

	// Bresenham edge stepper state
	typedef struct packed {
		logic signed [7:0] dx;
		logic signed [7:0] dy;
		logic              sxn;
		logic              syn;
		logic signed [8:0] err;
		logic signed [7:0] xn;
		logic signed [7:0] yn;
		logic signed [7:0] xe;
		logic signed [7:0] ye;
	} edge_t;

	typedef struct packed {
		edge_t nxt;
		logic  at_end;
		logic  ys;
		logic  xs;
	} step_t;

	// controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       vi_start;
		logic       vi_store;
		logic [1:0] vk;
		logic       half_init;
		logic       half;
		logic       edge_start;
		logic       edge_run;
		logic       lerp_set;
		logic       lerp_mul;
		logic       lerp_div;
		logic       lerp_store;
		logic [1:0] lsel;
		logic       span_init;
		logic       dep_start;
		logic       dep_store;
		logic       pix_write;
		logic       x_inc;
		logic       y_step;
		logic       clr_run;
		logic       out_load;
		logic       out_read;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [1:0] cmd;
		logic       div_done;
		logic       edges_done;
		logic       row_ok;
		logic       n_zero;
		logic       span_last;
		logic       clr_last;
		logic       out_free;
	} dp_stat_t;

	function automatic edge_t edge_init(logic [XY_W-1:0] x1, logic [XY_W-1:0] y1,
			logic [XY_W-1:0] x2, logic [XY_W-1:0] y2);
		edge_t e;
		e.dx  = (x2 > x1) ? 8'(x2 - x1) : 8'(x1 - x2);
		e.dy  = (y2 > y1) ? 8'(y2 - y1) : 8'(y1 - y2);
		e.sxn = !(x1 < x2);
		e.syn = !(y1 < y2);
		e.err = 9'(e.dx) - 9'(e.dy);
		e.xn  = 8'(x1);
		e.yn  = 8'(y1);
		e.xe  = 8'(x2);
		e.ye  = 8'(y2);
		return e;
	endfunction

	// one iteration of the stepper loop
	function automatic step_t edge_step(edge_t e);
		step_t r;
		logic signed [9:0] e2;
		logic signed [9:0] dx10;
		logic signed [9:0] dy10;
		r.nxt    = e;
		r.at_end = (e.xn == e.xe) && (e.yn == e.ye);
		e2   = {e.err, 1'b0};
		dx10 = 10'(e.dx);
		dy10 = 10'(e.dy);
		r.ys = e2 < dx10;
		r.xs = e2 > -dy10;
		r.nxt.err = e.err + (r.ys ? 9'(e.dx) : 9'sd0) - (r.xs ? 9'(e.dy) : 9'sd0);
		if (r.ys)
			r.nxt.yn = e.syn ? e.yn - 8'sd1 : e.yn + 8'sd1;
		if (r.xs)
			r.nxt.xn = e.sxn ? e.xn - 8'sd1 : e.xn + 8'sd1;
		return r;
	endfunction

endpackage

// ===== src/tri_zb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tri_zb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== src/tri_zb_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module tri_zb_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start)
				cnt_q <= CNT_W'(NUM_W);
			else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	// shift-subtract step
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = num_q;
endmodule

// ===== src/tri_zb_datapath.sv =====
// Datapath: vertex setup, edge steppers, interpolation, depth test and stores.
module tri_zb_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tri_zb_pkg::in_item_t in_data,
	input  tri_zb_pkg::dp_cmd_t  cmd,
	output tri_zb_pkg::dp_stat_t stat,
	input  logic                 out_ready,
	output logic                 out_valid,
	output tri_zb_pkg::out_item_t out_data
);
	import tri_zb_pkg::*;

	typedef struct packed {
		logic [XY_W-1:0] x;
		logic [XY_W-1:0] y;
		logic [15:0]     z;
	} vtx_t;

	in_item_t          in_q;
	logic [XY_W-1:0]   vx_q [3];
	logic [XY_W-1:0]   vy_q [3];
	logic [15:0]       vz_q [3];
	logic [INV_W-1:0]  vi_q [3];
	edge_t             e1_q, e2_q;
	logic signed [7:0] xp1_q, xp2_q;
	logic              fin1_q, fin2_q;
	logic              half_q;
	logic signed [7:0] y_q;
	logic [XY_W-1:0]   x_q, xe_q;
	logic [INV_W-1:0]  i1_q, i2_q, inv_q;
	logic [INV_W-1:0]  la_q, lb_q;
	logic signed [7:0] lk_q, ln_q;
	logic signed [41:0] prod_q;
	logic [DEPTH_W-1:0] dep_q;
	logic [ADDR_W-1:0] clr_q;
	out_item_t         out_q;
	logic              out_valid_q;

	vtx_t              sv [3];
	vtx_t              tv;
	step_t             st1, st2;
	logic [INV_W-1:0]  sa, sb;
	logic signed [7:0] sk, sn;
	logic signed [33:0] diff;
	logic [DIV_NUM_W-1:0] mag;
	logic [DIV_DEN_W-1:0] nmag;
	logic              neg;
	logic signed [41:0] sq;
	logic signed [41:0] lsum;
	logic [INV_W-1:0]  lres;
	logic              div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic              div_done;
	logic [DIV_NUM_W-1:0] quot;
	logic [ADDR_W-1:0] pix_addr, raddr, waddr;
	logic              we;
	logic [COLOR_W-1:0] rd_color;
	logic [DEPTH_W-1:0] rd_depth;
	logic signed [7:0] vy1s;

	// stable sort of the incoming vertices by row
	always_comb begin
		sv[0] = '{x: in_data.ax, y: in_data.ay, z: in_data.az};
		sv[1] = '{x: in_data.bx, y: in_data.by_row, z: in_data.bz};
		sv[2] = '{x: in_data.cx, y: in_data.cy, z: in_data.cz};
		tv    = '0;
		if (sv[1].y < sv[0].y) begin
			tv = sv[0]; sv[0] = sv[1]; sv[1] = tv;
		end
		if (sv[2].y < sv[1].y) begin
			tv = sv[1]; sv[1] = sv[2]; sv[2] = tv;
		end
		if (sv[1].y < sv[0].y) begin
			tv = sv[0]; sv[0] = sv[1]; sv[1] = tv;
		end
	end

	// stepper iterations
	assign st1 = edge_step(e1_q);
	assign st2 = edge_step(e2_q);

	// interpolation operand selection
	always_comb begin
		sa = i1_q;
		sb = i2_q;
		sk = 8'(x_q) - xp1_q;
		sn = xp2_q - xp1_q;
		case (cmd.lsel)
			LS_I1: begin
				if (!half_q) begin
					sa = vi_q[0]; sb = vi_q[1];
					sk = y_q - 8'(vy_q[0]);
					sn = 8'(vy_q[1]) - 8'(vy_q[0]);
				end else begin
					sa = vi_q[2]; sb = vi_q[1];
					sk = y_q - 8'(vy_q[2]);
					sn = 8'(vy_q[1]) - 8'(vy_q[2]);
				end
			end
			LS_I2: begin
				if (!half_q) begin
					sa = vi_q[0]; sb = vi_q[2];
					sk = y_q - 8'(vy_q[0]);
					sn = 8'(vy_q[2]) - 8'(vy_q[0]);
				end else begin
					sa = vi_q[2]; sb = vi_q[0];
					sk = y_q - 8'(vy_q[2]);
					sn = 8'(vy_q[0]) - 8'(vy_q[2]);
				end
			end
			default: begin
				sa = i1_q;
				sb = i2_q;
			end
		endcase
	end

	// signed interpolation arithmetic around the shared divider
	assign diff = $signed({1'b0, lb_q}) - $signed({1'b0, la_q});
	assign mag  = prod_q[41] ? DIV_NUM_W'(-prod_q) : DIV_NUM_W'(prod_q);
	assign nmag = ln_q[7] ? DIV_DEN_W'(-ln_q) : DIV_DEN_W'(ln_q);
	assign neg  = prod_q[41] ^ ln_q[7];
	assign sq   = neg ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
	assign lsum = $signed(42'({9'd0, la_q})) + sq;
	assign lres = (ln_q == 8'sd0) ? la_q : lsum[INV_W-1:0];

	// divider source selection
	always_comb begin
		div_start = cmd.vi_start | cmd.lerp_div | cmd.dep_start;
		div_num   = INV_NUM;
		div_den   = DIV_DEN_W'(vz_q[cmd.vk]);
		if (cmd.lerp_div) begin
			div_num = mag;
			div_den = nmag;
		end else if (cmd.dep_start) begin
			div_den = inv_q;
		end
	end

	tri_zb_div #(.NUM_W(DIV_NUM_W), .DEN_W(DIV_DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (quot)
	);

	// store addressing; the screen is 64 wide, so the index is {row, column}
	assign pix_addr = {y_q[XY_W-1:0], x_q};
	assign raddr    = (in_q.cmd == CMD_READ) ? {in_q.ay, in_q.ax} : pix_addr;
	assign we       = cmd.clr_run | (cmd.pix_write & (rd_depth > dep_q));
	assign waddr    = cmd.clr_run ? clr_q : pix_addr;

	tri_zb_ram #(.WIDTH(COLOR_W), .DEPTH(NPIX)) u_color (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (in_q.fill_color),
		.raddr (raddr),
		.rdata (rd_color)
	);

	tri_zb_ram #(.WIDTH(DEPTH_W), .DEPTH(NPIX)) u_depth (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.clr_run ? DMAX : dep_q),
		.raddr (raddr),
		.rdata (rd_depth)
	);

	// item, clear sweep counter and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cmd.load)
				in_q <= in_data;
			if (cmd.clr_run)
				clr_q <= clr_q + ADDR_W'(1);
			if (cmd.out_load) begin
				out_valid_q       <= 1'b1;
				out_q.pixel_color <= cmd.out_read ? rd_color : '0;
				out_q.pixel_depth <= cmd.out_read ? rd_depth : '0;
				out_q.status      <= cmd.out_read;
			end else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// triangle working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < 3; i++) begin
				vx_q[i] <= sv[i].x;
				vy_q[i] <= sv[i].y;
				vz_q[i] <= (sv[i].z == 16'd0) ? 16'd1 : sv[i].z;
			end
		end
		if (cmd.vi_store)
			vi_q[cmd.vk] <= quot[INV_W-1:0];
		if (cmd.half_init) begin
			half_q <= cmd.half;
			if (!cmd.half) begin
				e1_q <= edge_init(vx_q[0], vy_q[0], vx_q[1], vy_q[1]);
				e2_q <= edge_init(vx_q[0], vy_q[0], vx_q[2], vy_q[2]);
				y_q  <= 8'(vy_q[0]);
			end else begin
				e1_q <= edge_init(vx_q[2], vy_q[2], vx_q[1], vy_q[1]);
				e2_q <= edge_init(vx_q[2], vy_q[2], vx_q[0], vy_q[0]);
				y_q  <= 8'(vy_q[2]);
			end
		end
		if (cmd.edge_start) begin
			xp1_q  <= e1_q.xn;
			xp2_q  <= e2_q.xn;
			fin1_q <= 1'b0;
			fin2_q <= 1'b0;
		end
		// each stepper runs until its row changes or it sits on its end point
		if (cmd.edge_run && !fin1_q) begin
			if (st1.at_end)
				fin1_q <= 1'b1;
			else begin
				e1_q <= st1.nxt;
				if (st1.ys && st1.xs)
					xp1_q <= e1_q.xn;
				if (st1.ys)
					fin1_q <= 1'b1;
			end
		end
		if (cmd.edge_run && !fin2_q) begin
			if (st2.at_end)
				fin2_q <= 1'b1;
			else begin
				e2_q <= st2.nxt;
				if (st2.ys && st2.xs)
					xp2_q <= e2_q.xn;
				if (st2.ys)
					fin2_q <= 1'b1;
			end
		end
		if (cmd.lerp_set) begin
			la_q <= sa;
			lb_q <= sb;
			lk_q <= sk;
			ln_q <= sn;
		end
		if (cmd.lerp_mul)
			prod_q <= 42'(diff * lk_q);
		if (cmd.lerp_store) begin
			case (cmd.lsel)
				LS_I1:   i1_q  <= lres;
				LS_I2:   i2_q  <= lres;
				default: inv_q <= lres;
			endcase
		end
		if (cmd.span_init) begin
			x_q  <= (xp1_q < xp2_q) ? xp1_q[XY_W-1:0] : xp2_q[XY_W-1:0];
			xe_q <= (xp1_q < xp2_q) ? xp2_q[XY_W-1:0] : xp1_q[XY_W-1:0];
		end
		if (cmd.x_inc)
			x_q <= x_q + XY_W'(1);
		if (cmd.y_step)
			y_q <= half_q ? y_q - 8'sd1 : y_q + 8'sd1;
		// depth from inverse depth, saturating
		if (cmd.dep_store)
			dep_q <= (quot[DIV_NUM_W-1:DEPTH_W] != '0) ? DMAX : quot[DEPTH_W-1:0];
	end

	assign vy1s = 8'(vy_q[1]);

	// status to the controller
	always_comb begin
		stat.cmd        = in_q.cmd;
		stat.div_done   = div_done;
		stat.edges_done = fin1_q & fin2_q;
		stat.row_ok     = half_q ? (y_q >= vy1s) : (y_q <= vy1s);
		stat.n_zero     = (ln_q == 8'sd0);
		stat.span_last  = (x_q == xe_q);
		stat.clr_last   = (clr_q == ADDR_W'(NPIX - 1));
		stat.out_free   = !out_valid_q | out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// ===== src/tri_zb_ctrl.sv =====
// Controller state machine sequencing clear, draw and read commands.
module tri_zb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           in_cmd,
	input  tri_zb_pkg::dp_stat_t stat,
	output tri_zb_pkg::dp_cmd_t  cmd
);
	import tri_zb_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_CLR   = 5'd1;
	localparam logic [4:0] S_RD    = 5'd2;
	localparam logic [4:0] S_RD2   = 5'd3;
	localparam logic [4:0] S_VI_GO = 5'd4;
	localparam logic [4:0] S_VI_WT = 5'd5;
	localparam logic [4:0] S_HALF  = 5'd6;
	localparam logic [4:0] S_ROW   = 5'd7;
	localparam logic [4:0] S_EDGE0 = 5'd8;
	localparam logic [4:0] S_EDGE  = 5'd9;
	localparam logic [4:0] S_L_SET = 5'd10;
	localparam logic [4:0] S_L_MUL = 5'd11;
	localparam logic [4:0] S_L_DIV = 5'd12;
	localparam logic [4:0] S_L_WT  = 5'd13;
	localparam logic [4:0] S_SPAN  = 5'd14;
	localparam logic [4:0] S_DP_GO = 5'd15;
	localparam logic [4:0] S_DP_WT = 5'd16;
	localparam logic [4:0] S_TEST  = 5'd17;
	localparam logic [4:0] S_DONE  = 5'd18;

	logic [4:0] state_q, state_d;
	logic [1:0] vk_q, vk_d;
	logic [1:0] lsel_q, lsel_d;
	logic       half_q, half_d;
	logic       boot_q, boot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			vk_q    <= '0;
			lsel_q  <= LS_I1;
			half_q  <= 1'b0;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			vk_q    <= vk_d;
			lsel_q  <= lsel_d;
			half_q  <= half_d;
			boot_q  <= boot_d;
		end
	end

	assign in_ready = (state_q == S_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d  = state_q;
		vk_d     = vk_q;
		lsel_d   = lsel_q;
		half_d   = half_q;
		boot_d   = boot_q;
		cmd      = '0;
		cmd.vk   = vk_q;
		cmd.lsel = lsel_q;
		cmd.half = half_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (in_cmd)
						CMD_CLEAR: state_d = S_CLR;
						CMD_DRAW: begin
							vk_d    = 2'd0;
							state_d = S_VI_GO;
						end
						CMD_READ: state_d = S_RD;
						default:  state_d = S_DONE;
					endcase
				end
			end
			S_CLR: begin
				cmd.clr_run = 1'b1;
				if (stat.clr_last) begin
					boot_d  = 1'b0;
					state_d = boot_q ? S_IDLE : S_DONE;
				end
			end
			S_RD: state_d = S_RD2;
			S_RD2: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_read = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_VI_GO: begin
				cmd.vi_start = 1'b1;
				state_d      = S_VI_WT;
			end
			S_VI_WT: begin
				if (stat.div_done) begin
					cmd.vi_store = 1'b1;
					if (vk_q == 2'd2) begin
						half_d  = 1'b0;
						state_d = S_HALF;
					end else begin
						vk_d    = vk_q + 2'd1;
						state_d = S_VI_GO;
					end
				end
			end
			S_HALF: begin
				cmd.half_init = 1'b1;
				state_d       = S_ROW;
			end
			S_ROW: begin
				if (stat.row_ok)
					state_d = S_EDGE0;
				else if (!half_q) begin
					half_d  = 1'b1;
					state_d = S_HALF;
				end else
					state_d = S_DONE;
			end
			S_EDGE0: begin
				cmd.edge_start = 1'b1;
				state_d        = S_EDGE;
			end
			S_EDGE: begin
				if (stat.edges_done) begin
					lsel_d  = LS_I1;
					state_d = S_L_SET;
				end else
					cmd.edge_run = 1'b1;
			end
			S_L_SET: begin
				cmd.lerp_set = 1'b1;
				state_d      = S_L_MUL;
			end
			S_L_MUL: begin
				cmd.lerp_mul = 1'b1;
				state_d      = stat.n_zero ? S_L_WT : S_L_DIV;
			end
			S_L_DIV: begin
				cmd.lerp_div = 1'b1;
				state_d      = S_L_WT;
			end
			S_L_WT: begin
				// zero span skips the divider
				if (stat.n_zero || stat.div_done) begin
					cmd.lerp_store = 1'b1;
					case (lsel_q)
						LS_I1: begin
							lsel_d  = LS_I2;
							state_d = S_L_SET;
						end
						LS_I2:   state_d = S_SPAN;
						default: state_d = S_DP_GO;
					endcase
				end
			end
			S_SPAN: begin
				cmd.span_init = 1'b1;
				lsel_d        = LS_PIX;
				state_d       = S_L_SET;
			end
			S_DP_GO: begin
				cmd.dep_start = 1'b1;
				state_d       = S_DP_WT;
			end
			S_DP_WT: begin
				if (stat.div_done) begin
					cmd.dep_store = 1'b1;
					state_d       = S_TEST;
				end
			end
			S_TEST: begin
				cmd.pix_write = 1'b1;
				if (stat.span_last) begin
					cmd.y_step = 1'b1;
					state_d    = S_ROW;
				end else begin
					cmd.x_inc = 1'b1;
					state_d   = S_L_SET;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== src/triangle_rasterizer_z_buffer_unit.sv =====
// Top level of the scanline triangle rasterizer with color and depth stores.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------
//  input    | in_valid / in_ready     | in_data  (cmd, vertices, color)
//  output   | out_valid / out_ready   | out_data (color, depth, status)
//
// One item at a time. Read passes S_RD and S_RD2; clear writes one store entry per cycle.
// Draw: per vertex an inverse depth, per row the edge steps plus two interpolations,
// and per pixel one interpolation and one depth reciprocal, all on the shared 40-bit
// serial divider; a one-pixel span skips the division of its interpolation.
// After reset a clearing pass fills the stores; no item is taken then.
// A waiting result holds only the last step of the next item.
module triangle_rasterizer_z_buffer_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tri_zb_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tri_zb_pkg::out_item_t out_data
);
	import tri_zb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tri_zb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_cmd   (in_data.cmd),
		.stat     (stat),
		.cmd      (cmd)
	);

	tri_zb_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);
endmodule

// ===== bench/tb.sv =====
// Testbench for the triangle rasterizer with depth store: directed and random items
`timescale 1ns / 100ps

module tb;
	import tri_zb_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam longint INV_ONE = 64'd1 << 32;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;

	// shadow stores and pending read-back results
	logic [COLOR_W-1:0] color_mem [NPIX];
	logic [DEPTH_W-1:0] depth_mem [NPIX];
	out_item_t pending_px [$];
	int mismatches = 0;
	int cycles = 0;
	bit calm = 1'b0;
	int stall_left = 0;
	int last_x = 0, last_y = 0, last_w = 0;

	// edge stepper state, two steppers
	int s_dx [2], s_dy [2], s_sx [2], s_sy [2], s_err [2];
	int s_xn [2], s_yn [2], s_xe [2], s_ye [2];

	always #2 clk = ~clk;

	triangle_rasterizer_z_buffer_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	// depth test and write of one pixel
	function automatic void plot_px(int x, int y, longint inv, logic [31:0] c);
		longint d;
		logic [15:0] dep;
		int idx;
		if (x < 0 || y < 0 || x >= SCREEN_W || y >= SCREEN_H)
			return;
		if (inv <= 0)
			dep = DMAX;
		else begin
			d = INV_ONE / inv;
			dep = (d > 65535) ? DMAX : 16'(d);
		end
		idx = y * SCREEN_W + x;
		if (depth_mem[idx] > dep) begin
			color_mem[idx] = c;
			depth_mem[idx] = dep;
		end
	endfunction

	function automatic longint interp(longint a, longint b, longint k, longint n);
		if (n == 0)
			return a;
		return a + (b - a) * k / n;
	endfunction

	function automatic void fill_row(int x1, longint i1, int x2, longint i2, int y,
			logic [31:0] c);
		int x, xend;
		if (x1 == x2) begin
			plot_px(x1, y, i1, c);
			return;
		end
		x = (x1 < x2) ? x1 : x2;
		xend = (x1 < x2) ? x2 : x1;
		for (; x <= xend; x++)
			plot_px(x, y, interp(i1, i2, x - x1, x2 - x1), c);
	endfunction

	function automatic void edge_setup(int s, int x1, int y1, int x2, int y2);
		s_dx[s] = (x2 > x1) ? x2 - x1 : x1 - x2;
		s_dy[s] = (y2 > y1) ? y2 - y1 : y1 - y2;
		s_sx[s] = (x1 < x2) ? 1 : -1;
		s_sy[s] = (y1 < y2) ? 1 : -1;
		s_err[s] = s_dx[s] - s_dy[s];
		s_xn[s] = x1;
		s_yn[s] = y1;
		s_xe[s] = x2;
		s_ye[s] = y2;
	endfunction

	// advance one row; returns column before the row step
	function automatic int edge_advance(int s);
		int xp, e2, n;
		bit done;
		xp = s_xn[s];
		done = 1'b0;
		for (n = 0; n < s_dx[s] + s_dy[s] + 2; n++) begin
			if (s_xn[s] == s_xe[s] && s_yn[s] == s_ye[s])
				break;
			e2 = 2 * s_err[s];
			if (e2 < s_dx[s]) begin
				s_err[s] += s_dx[s];
				s_yn[s] += s_sy[s];
				done = 1'b1;
			end
			if (e2 > -s_dy[s]) begin
				s_err[s] -= s_dy[s];
				if (done)
					xp = s_xn[s];
				s_xn[s] += s_sx[s];
			end
			if (done)
				break;
		end
		return xp;
	endfunction

	function automatic void raster_tri(in_item_t it);
		int vx [3], vy [3];
		longint vi [3];
		int zz [3];
		int i, j, y, x1, x2, tx, ty;
		longint ti, i1, i2;
		vx[0] = it.ax; vy[0] = it.ay; zz[0] = it.az;
		vx[1] = it.bx; vy[1] = it.by_row; zz[1] = it.bz;
		vx[2] = it.cx; vy[2] = it.cy; zz[2] = it.cz;
		for (i = 0; i < 3; i++)
			vi[i] = INV_ONE / ((zz[i] == 0) ? 1 : zz[i]);
		// stable insertion sort by row
		for (i = 1; i < 3; i++)
			for (j = i; j > 0 && vy[j] < vy[j-1]; j--) begin
				tx = vx[j]; vx[j] = vx[j-1]; vx[j-1] = tx;
				ty = vy[j]; vy[j] = vy[j-1]; vy[j-1] = ty;
				ti = vi[j]; vi[j] = vi[j-1]; vi[j-1] = ti;
			end
		edge_setup(0, vx[0], vy[0], vx[1], vy[1]);
		edge_setup(1, vx[0], vy[0], vx[2], vy[2]);
		for (y = vy[0]; y <= vy[1]; y++) begin
			x1 = edge_advance(0);
			i1 = interp(vi[0], vi[1], y - vy[0], vy[1] - vy[0]);
			x2 = edge_advance(1);
			i2 = interp(vi[0], vi[2], y - vy[0], vy[2] - vy[0]);
			fill_row(x1, i1, x2, i2, y, it.fill_color);
		end
		edge_setup(0, vx[2], vy[2], vx[1], vy[1]);
		edge_setup(1, vx[2], vy[2], vx[0], vy[0]);
		for (y = vy[2]; y >= vy[1]; y--) begin
			x1 = edge_advance(0);
			i1 = interp(vi[2], vi[1], y - vy[2], vy[1] - vy[2]);
			x2 = edge_advance(1);
			i2 = interp(vi[2], vi[0], y - vy[2], vy[0] - vy[2]);
			fill_row(x1, i1, x2, i2, y, it.fill_color);
		end
	endfunction

	function automatic out_item_t predict_px(in_item_t it);
		out_item_t r;
		int idx;
		r = '0;
		case (it.cmd)
			CMD_CLEAR: begin
				for (idx = 0; idx < NPIX; idx++) begin
					color_mem[idx] = it.fill_color;
					depth_mem[idx] = DMAX;
				end
			end
			CMD_DRAW: raster_tri(it);
			CMD_READ: begin
				idx = it.ay * SCREEN_W + it.ax;
				r.pixel_color = color_mem[idx];
				r.pixel_depth = depth_mem[idx];
				r.status = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic int pick_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(20, 80);
		return $urandom_range(0, 3);
	endfunction

	// send one item, predict its result on acceptance
	task automatic send_item(in_item_t it);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = it;
		do @(posedge clk); while (!in_ready);
		pending_px.push_back(predict_px(it));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic wait_empty();
		while (pending_px.size() != 0)
			@(posedge clk);
	endtask

	function automatic in_item_t make_item(logic [1:0] c, int ax, int ay, int az,
			int bx, int by, int bz, int cx, int cy, int cz, logic [31:0] col);
		in_item_t it;
		it.cmd = c;
		it.ax = ax; it.ay = ay; it.az = az;
		it.bx = bx; it.by_row = by; it.bz = bz;
		it.cx = cx; it.cy = cy; it.cz = cz;
		it.fill_color = col;
		return it;
	endfunction

	task automatic read_at(int x, int y);
		send_item(make_item(CMD_READ, x, y, 0, 0, 0, 0, 0, 0, 0, $urandom));
	endtask

	function automatic int rand_z();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return $urandom_range(1, 16);
			default: return $urandom_range(1, 65535);
		endcase
	endfunction

	function automatic int clamp63(int v);
		return (v > 63) ? 63 : v;
	endfunction

	// result checker
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_px.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: %h", out_data);
			end else begin
				want = pending_px.pop_front();
				if (out_data.pixel_color !== want.pixel_color ||
						out_data.pixel_depth !== want.pixel_depth ||
						out_data.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: color %h/%h depth %h/%h status %b/%b (exp/got)",
							want.pixel_color, out_data.pixel_color,
							want.pixel_depth, out_data.pixel_depth,
							want.status, out_data.status);
				end
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 39) == 0) begin
			stall_left = $urandom_range(20, 80);
			out_ready <= 1'b0;
		end else
			out_ready <= calm || ($urandom_range(0, 3) != 0);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic test_clear_and_corners();
		read_at(0, 0);
		read_at(63, 63);
		send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
		read_at(63, 0);
		read_at(0, 63);
	endtask

	task automatic test_draw_shapes();
		// screen-corner triangle over half the screen, extreme depths including zero depth
		send_item(make_item(CMD_DRAW, 0, 0, 0, 63, 0, 65535, 0, 63, 1, 32'h1234_5678));
		read_at(0, 0);
		read_at(31, 31);
		read_at(62, 1);
		// flat bottom, equal rows keep order, single point
		send_item(make_item(CMD_DRAW, 40, 40, 100, 45, 48, 200, 35, 48, 300, 32'hA5A5_5A5A));
		read_at(40, 44);
		send_item(make_item(CMD_DRAW, 10, 50, 50, 20, 50, 60, 15, 50, 70, 32'h0F0F_F0F0));
		read_at(15, 50);
		send_item(make_item(CMD_DRAW, 5, 5, 1, 5, 5, 1, 5, 5, 1, 32'h8000_0001));
		read_at(5, 5);
	endtask

	task automatic test_depth_order();
		// farther triangle must not overwrite the nearer one
		send_item(make_item(CMD_DRAW, 20, 10, 500, 28, 18, 500, 20, 18, 500, 32'hCAFE_0001));
		send_item(make_item(CMD_DRAW, 20, 10, 9000, 28, 18, 9000, 20, 18, 9000, 32'hCAFE_0002));
		read_at(22, 16);
		send_item(make_item(CMD_DRAW, 20, 10, 400, 28, 18, 400, 20, 18, 400, 32'hCAFE_0003));
		read_at(22, 16);
	endtask

	task automatic test_unused_cmd();
		send_item(make_item(CMD_UNUSED, 63, 63, 65535, 63, 63, 65535, 63, 63, 65535, '1));
		read_at(63, 63);
	endtask

	task automatic test_random(int count);
		int i, k, sz, bx0, by0;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 20)
				calm = 1'b1;
			else if (i % 40 == 30)
				calm = 1'b0;
			k = $urandom_range(0, 99);
			if (k < 2) begin
				send_item(make_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, $urandom));
			end else if (k < 4) begin
				send_item(make_item(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
			end else if (k < 40) begin
				sz = ($urandom_range(0, 14) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
				bx0 = $urandom_range(0, 63);
				by0 = $urandom_range(0, 63);
				last_x = bx0; last_y = by0; last_w = sz;
				send_item(make_item(CMD_DRAW,
					clamp63(bx0 + $urandom_range(0, sz)), clamp63(by0 + $urandom_range(0, sz)),
					rand_z(),
					clamp63(bx0 + $urandom_range(0, sz)), clamp63(by0 + $urandom_range(0, sz)),
					rand_z(),
					clamp63(bx0 + $urandom_range(0, sz)), clamp63(by0 + $urandom_range(0, sz)),
					rand_z(), $urandom));
			end else if (k < 85) begin
				read_at(clamp63(last_x + $urandom_range(0, last_w)),
					clamp63(last_y + $urandom_range(0, last_w)));
			end else
				read_at($urandom_range(0, 63), $urandom_range(0, 63));
		end
		calm = 1'b0;
	endtask

	task automatic test_drain_pause();
		wait_empty();
		read_at(last_x, last_y);
		read_at(63, 63);
	endtask

	initial begin
		int n;
		for (n = 0; n < NPIX; n++) begin
			color_mem[n] = '0;
			depth_mem[n] = DMAX;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_clear_and_corners();
		test_draw_shapes();
		test_depth_order();
		test_unused_cmd();
		test_random(59);
		test_drain_pause();
		test_random(59);
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/tri_zb_pkg.sv
src/tri_zb_ram.sv
src/tri_zb_div.sv
src/tri_zb_datapath.sv
src/tri_zb_ctrl.sv
src/triangle_rasterizer_z_buffer_unit.sv
bench/tb.sv
